>>> hdl/bihv_pkg.sv
package bihv_pkg;

    localparam int unsigned COUNT_W  = 33;
    localparam int unsigned HDR_N    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] HDR_COUNT = 33'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [15:0]        HDR_LEN   = 16'd16;
    localparam logic [4:0]         ENTRY_OFS = 5'd16;
    localparam logic [15:0]        CRC_POLY  = 16'h1021;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;

    // verdict codes
    localparam logic [1:0] VERDICT_OK    = 2'd0;
    localparam logic [1:0] VERDICT_RANGE = 2'd1;
    localparam logic [1:0] VERDICT_MAGIC = 2'd2;
    localparam logic [1:0] VERDICT_CRC   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [4:0]  start_offset;
        logic [31:0] declared_size;
    } t_out_item;

    // what the stream side hands to the verdict logic for the byte being taken
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [15:0]        crc;
        logic [31:0]        magic;
        logic [15:0]        version;
        logic [15:0]        hdr_len;
        logic [31:0]        size_field;
        logic [15:0]        hdr_crc;
    } t_hdr_status;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/boot_image_header_validator.sv
// A verdict appears on o_out_valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; input stalls only while a verdict waits and the
// receiver holds off. The byte-wide CRC step sits between state and verdict registers.
// Reset (synchronous, active low) clears the byte counter and the verdict valid flag
// and returns the configuration registers to their defaults; header bytes are not reset.
module boot_image_header_validator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bihv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bihv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  bihv_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output bihv_pkg::t_out_item                  o_out_item
);
    import bihv_pkg::*;

    logic [31:0] r_expected_magic;
    logic [15:0] r_expected_version;
    logic [15:0] r_crc_seed;
    logic        accept;
    t_hdr_status status;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic   <= 32'd0;
            r_expected_version <= 16'd1;
            r_crc_seed         <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAGIC:   r_expected_magic   <= i_cfg_data;
                CFG_VERSION: r_expected_version <= i_cfg_data[15:0];
                CFG_SEED:    r_crc_seed         <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    bihv_stream u_stream (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_crc_seed (r_crc_seed),
        .o_status   (status)
    );

    bihv_verdict u_verdict (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_take             (accept && i_in_item.last_byte),
        .i_status           (status),
        .i_expected_magic   (r_expected_magic),
        .i_expected_version (r_expected_version),
        .i_out_ready        (i_out_ready),
        .o_in_ready         (o_in_ready),
        .o_out_valid        (o_out_valid),
        .o_out_item         (o_out_item)
    );

endmodule

>>> hdl/bihv_stream.sv
module bihv_stream (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  bihv_pkg::t_in_item    i_item,
    input  logic [15:0]           i_crc_seed,
    output bihv_pkg::t_hdr_status o_status
);
    import bihv_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] count_inc;
    logic [15:0]        r_crc;
    logic [15:0]        n_crc;
    logic [15:0]        crc_base;
    logic [7:0]         r_hdr [HDR_N];
    logic [31:0]        size_field;

    assign size_field = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};

    // seed is picked up on the first byte of each image
    assign crc_base  = (r_count == '0) ? i_crc_seed : r_crc;
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        if (r_count >= HDR_COUNT && r_count < {1'b0, size_field}) begin
            n_crc = crc16_byte(crc_base, i_item.data_byte);
        end else begin
            n_crc = crc_base;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            n_count = i_item.last_byte ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_count < HDR_COUNT) begin
            r_hdr[r_count[3:0]] <= i_item.data_byte;
        end
    end

    // header bytes 14 and 15 are never read, so the byte written this cycle needs no bypass
    assign o_status.count      = count_inc;
    assign o_status.crc        = n_crc;
    assign o_status.magic      = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign o_status.version    = {r_hdr[5], r_hdr[4]};
    assign o_status.hdr_len    = {r_hdr[7], r_hdr[6]};
    assign o_status.size_field = size_field;
    assign o_status.hdr_crc    = {r_hdr[13], r_hdr[12]};

    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == COUNT_MAX && !(i_accept && i_item.last_byte)) |=> r_count == COUNT_MAX)
        else $error("byte counter left saturation");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.last_byte) |=> r_count == '0)
        else $error("byte counter not cleared after last byte");

    a_hdr_no_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_count < HDR_COUNT) |-> n_crc == crc_base)
        else $error("header byte went through the CRC");

endmodule

>>> hdl/bihv_verdict.sv
module bihv_verdict (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  bihv_pkg::t_hdr_status i_status,
    input  logic [31:0]           i_expected_magic,
    input  logic [15:0]           i_expected_version,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output bihv_pkg::t_out_item   o_out_item
);
    import bihv_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        n_item.start_offset  = '0;
        n_item.declared_size = '0;
        if (i_status.count < HDR_COUNT) begin
            n_item.verdict = VERDICT_RANGE;
        end else begin
            n_item.declared_size = i_status.size_field;
            priority if (i_status.magic != i_expected_magic) begin
                n_item.verdict = VERDICT_MAGIC;
            end else if (i_status.version != i_expected_version ||
                         i_status.hdr_len != HDR_LEN ||
                         i_status.size_field <= {16'd0, i_status.hdr_len} ||
                         {1'b0, i_status.size_field} > i_status.count) begin
                n_item.verdict = VERDICT_RANGE;
            end else if (i_status.crc != i_status.hdr_crc) begin
                n_item.verdict = VERDICT_CRC;
            end else begin
                n_item.verdict      = VERDICT_OK;
                n_item.start_offset = ENTRY_OFS;
            end
        end
    end

    // output register doubles as the skid stage
    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |=> r_valid)
        else $error("verdict lost");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_item.verdict == VERDICT_OK) == (r_item.start_offset == ENTRY_OFS)))
        else $error("entry offset does not match verdict");

    a_size_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_item.verdict == VERDICT_OK || r_item.verdict == VERDICT_CRC))
        |-> r_item.declared_size > 32'd16)
        else $error("passing header with short image size");

endmodule
